### rtl/core/set_assoc_lru_write_through_cache_assert.svh
// Assertion macros used by the checker file.
`ifndef SET_ASSOC_LRU_WRITE_THROUGH_CACHE_ASSERT_SVH
`define SET_ASSOC_LRU_WRITE_THROUGH_CACHE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SACW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cache check failed");

// next-cycle implication
`define SACW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cache check failed");

`endif

### rtl/core/sacw_pkg.sv
package sacw_pkg;

	localparam int unsigned MEMORY_BYTES_DEF = 65536;
	localparam int unsigned CACHE_BYTES_DEF  = 4096;
	localparam int unsigned LINE_BYTES_DEF   = 128;
	localparam int unsigned NUM_WAYS_DEF     = 4;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        hit;
		logic [31:0] access_count;
		logic [31:0] miss_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_FLUSH
	} state_t;

	// result of the tag compare, handed to the controller
	typedef struct packed {
		logic hit;
		logic row_wr;
	} look_t;

endpackage

### rtl/core/set_assoc_lru_write_through_cache.sv
// Read and write: the request beat starts the memory and tag reads; the lookup state then does
// the tag compare and write back and registers the result. Flush clears one set row a cycle.
// One item at a time: a request is taken only in the idle state. A pending result does not
// block the next request, but a lookup holds while the earlier result waits on rsp_ready.
// Reset: counters and state clear at once, then a clearing pass over max(MEMORY_BYTES,
// number of sets) addresses clears main memory and the tag rows; no request is taken meanwhile.
module set_assoc_lru_write_through_cache #(
	parameter int unsigned MEMORY_BYTES = sacw_pkg::MEMORY_BYTES_DEF,
	parameter int unsigned CACHE_BYTES  = sacw_pkg::CACHE_BYTES_DEF,
	parameter int unsigned LINE_BYTES   = sacw_pkg::LINE_BYTES_DEF,
	parameter int unsigned NUM_WAYS     = sacw_pkg::NUM_WAYS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  sacw_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output sacw_pkg::rsp_t rsp
);

	localparam int unsigned SETS_RAW  = CACHE_BYTES / (LINE_BYTES * NUM_WAYS);
	localparam int unsigned NUM_SETS  = (SETS_RAW > 0) ? SETS_RAW : 1;
	localparam int unsigned MEM_AW    = $clog2(MEMORY_BYTES);
	localparam int unsigned SET_AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int unsigned TAG_BITS  = $clog2(MEMORY_BYTES / (LINE_BYTES * NUM_SETS));
	localparam int unsigned TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
	localparam int unsigned RANK_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int unsigned ROW_W     = NUM_WAYS * (1 + TAG_W + RANK_W);
	localparam int unsigned CLR_DEPTH = (MEMORY_BYTES > NUM_SETS) ? MEMORY_BYTES : NUM_SETS;
	localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

	sacw_pkg::state_t state_q, state_d;
	logic [CLR_W-1:0]  clr_q;
	logic [MEM_AW-1:0] maddr_q;
	logic [SET_AW-1:0] set_q;
	logic [TAG_W-1:0]  tag_q;
	logic [1:0]        op_q;
	logic [7:0]        data_q;
	logic [31:0]       acc_q, miss_q;
	logic              rsp_valid_q;
	sacw_pkg::rsp_t    rsp_q;

	logic [MEM_AW-1:0] req_maddr, req_block;
	logic [SET_AW-1:0] req_set;
	logic [TAG_W-1:0]  req_tag;
	logic              req_fire, out_free, clr_mem_ok, clr_set_ok, clr_last, flush_last;
	logic              mem_we, tag_we, rsp_load, clr_inc;
	logic [MEM_AW-1:0] mem_waddr;
	logic [7:0]        mem_wdata, mem_rdata;
	logic [SET_AW-1:0] tag_waddr;
	logic [ROW_W-1:0]  tag_wdata, tag_rdata, new_row, clear_row;
	sacw_pkg::look_t   look;
	logic              is_access, is_miss;
	logic [31:0]       acc_n, miss_n;

	assign req_maddr = MEM_AW'(req.address);
	assign req_block = MEM_AW'(req_maddr / LINE_BYTES);
	assign req_set   = SET_AW'(req_block % NUM_SETS);
	assign req_tag   = TAG_W'(req_block / NUM_SETS);

	assign req_ready = (state_q == sacw_pkg::ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign clr_mem_ok = ((CLR_W+1)'(clr_q) < (CLR_W+1)'(MEMORY_BYTES));
	assign clr_set_ok = ((CLR_W+1)'(clr_q) < (CLR_W+1)'(NUM_SETS));
	assign clr_last   = (clr_q == CLR_W'(CLR_DEPTH - 1));
	assign flush_last = (clr_q == CLR_W'(NUM_SETS - 1));

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			clear_row[w] = 1'b0;
			clear_row[NUM_WAYS + w*TAG_W +: TAG_W] = '0;
			clear_row[NUM_WAYS + NUM_WAYS*TAG_W + w*RANK_W +: RANK_W] = RANK_W'(w);
		end
	end

	sacw_lookup #(
		.NUM_WAYS(NUM_WAYS),
		.TAG_W   (TAG_W),
		.RANK_W  (RANK_W)
	) u_lookup (
		.is_read(op_q == sacw_pkg::OP_READ),
		.tag    (tag_q),
		.row    (tag_rdata),
		.look   (look),
		.new_row(new_row)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sacw_pkg::ST_CLEAR: if (clr_last) state_d = sacw_pkg::ST_IDLE;
			sacw_pkg::ST_IDLE: begin
				if (req_fire) begin
					state_d = (req.operation == sacw_pkg::OP_FLUSH) ?
						sacw_pkg::ST_FLUSH : sacw_pkg::ST_LOOKUP;
				end
			end
			sacw_pkg::ST_LOOKUP: if (out_free) state_d = sacw_pkg::ST_IDLE;
			sacw_pkg::ST_FLUSH: if (flush_last && out_free) state_d = sacw_pkg::ST_IDLE;
			default: state_d = sacw_pkg::ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		mem_we    = 1'b0;
		tag_we    = 1'b0;
		rsp_load  = 1'b0;
		clr_inc   = 1'b0;
		mem_waddr = maddr_q;
		mem_wdata = data_q;
		tag_waddr = set_q;
		tag_wdata = new_row;
		unique case (state_q)
			sacw_pkg::ST_CLEAR: begin
				mem_we    = clr_mem_ok;
				tag_we    = clr_set_ok;
				mem_waddr = clr_q[MEM_AW-1:0];
				mem_wdata = '0;
				tag_waddr = clr_q[SET_AW-1:0];
				tag_wdata = clear_row;
				clr_inc   = 1'b1;
			end
			sacw_pkg::ST_IDLE: ;
			sacw_pkg::ST_LOOKUP: begin
				mem_we   = out_free && (op_q == sacw_pkg::OP_WRITE);
				tag_we   = out_free && (op_q == sacw_pkg::OP_READ ||
					(op_q == sacw_pkg::OP_WRITE && look.row_wr));
				rsp_load = out_free;
			end
			sacw_pkg::ST_FLUSH: begin
				tag_we    = 1'b1;
				tag_waddr = clr_q[SET_AW-1:0];
				tag_wdata = clear_row;
				clr_inc   = !flush_last;
				rsp_load  = flush_last && out_free;
			end
			default: ;
		endcase
	end

	sacw_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (req_fire),
		.raddr(req_maddr),
		.rdata(mem_rdata)
	);

	sacw_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_tags (
		.clk  (clk),
		.we   (tag_we),
		.waddr(tag_waddr),
		.wdata(tag_wdata),
		.re   (req_fire),
		.raddr(req_set),
		.rdata(tag_rdata)
	);

	// lines always mirror main memory (write-through), so a read returns memory data
	assign is_access = (state_q == sacw_pkg::ST_LOOKUP) &&
		(op_q == sacw_pkg::OP_READ || op_q == sacw_pkg::OP_WRITE);
	assign is_miss   = is_access && !look.hit;
	assign acc_n     = acc_q + 32'(is_access);
	assign miss_n    = miss_q + 32'(is_miss);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sacw_pkg::ST_CLEAR;
			clr_q       <= '0;
			acc_q       <= '0;
			miss_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_fire) begin
				clr_q <= '0;
			end else if (clr_inc) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (rsp_load) begin
				acc_q       <= acc_n;
				miss_q      <= miss_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			maddr_q <= req_maddr;
			set_q   <= req_set;
			tag_q   <= req_tag;
			op_q    <= req.operation;
			data_q  <= req.write_data;
		end
		if (rsp_load) begin
			rsp_q.read_data    <= (state_q == sacw_pkg::ST_LOOKUP &&
				op_q == sacw_pkg::OP_READ) ? mem_rdata : 8'd0;
			rsp_q.hit          <= is_access && look.hit;
			rsp_q.access_count <= acc_n;
			rsp_q.miss_count   <= miss_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/sacw_ram.sv
module sacw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/sacw_lookup.sv
// Tag compare, victim choice and LRU rank update for one set row.
// Row layout: {ranks, tags, valid}.
module sacw_lookup #(
	parameter int unsigned NUM_WAYS = 4,
	parameter int unsigned TAG_W    = 6,
	parameter int unsigned RANK_W   = 2,
	localparam int unsigned ROW_W   = NUM_WAYS * (1 + TAG_W + RANK_W)
) (
	input  logic             is_read,
	input  logic [TAG_W-1:0] tag,
	input  logic [ROW_W-1:0] row,
	output sacw_pkg::look_t  look,
	output logic [ROW_W-1:0] new_row
);

	logic [NUM_WAYS-1:0] valid;
	logic [NUM_WAYS-1:0] n_valid;
	logic [TAG_W-1:0]    tags [NUM_WAYS];
	logic [TAG_W-1:0]    n_tags [NUM_WAYS];
	logic [RANK_W-1:0]   ranks [NUM_WAYS];
	logic [RANK_W-1:0]   n_ranks [NUM_WAYS];
	logic [NUM_WAYS-1:0] hit_vec;
	logic [RANK_W-1:0]   hit_way;
	logic [RANK_W-1:0]   victim;
	logic [RANK_W-1:0]   way;
	logic [RANK_W-1:0]   old_rank;
	logic                found_inv;
	logic                found_lru;
	logic                found_hit;

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			valid[w] = row[w];
			tags[w]  = row[NUM_WAYS + w*TAG_W +: TAG_W];
			ranks[w] = row[NUM_WAYS + NUM_WAYS*TAG_W + w*RANK_W +: RANK_W];
			hit_vec[w] = valid[w] && (tags[w] == tag);
		end

		hit_way   = '0;
		found_hit = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (hit_vec[w] && !found_hit) begin
				hit_way   = RANK_W'(w);
				found_hit = 1'b1;
			end
		end

		// first invalid way, else the way of rank zero (ranks are a permutation)
		victim    = '0;
		found_inv = 1'b0;
		found_lru = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (!valid[w] && !found_inv) begin
				victim    = RANK_W'(w);
				found_inv = 1'b1;
			end
		end
		if (!found_inv) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (ranks[w] == '0 && !found_lru) begin
					victim    = RANK_W'(w);
					found_lru = 1'b1;
				end
			end
		end

		way      = found_hit ? hit_way : victim;
		old_rank = ranks[way];
		n_valid  = valid;
		for (int w = 0; w < NUM_WAYS; w++) begin
			n_tags[w]  = tags[w];
			n_ranks[w] = (ranks[w] > old_rank) ? ranks[w] - RANK_W'(1) : ranks[w];
		end
		n_ranks[way] = RANK_W'(NUM_WAYS - 1);
		if (!found_hit) begin
			n_valid[way] = 1'b1;
			n_tags[way]  = tag;
		end

		for (int w = 0; w < NUM_WAYS; w++) begin
			new_row[w] = n_valid[w];
			new_row[NUM_WAYS + w*TAG_W +: TAG_W] = n_tags[w];
			new_row[NUM_WAYS + NUM_WAYS*TAG_W + w*RANK_W +: RANK_W] = n_ranks[w];
		end

		look.hit    = found_hit;
		look.row_wr = is_read || found_hit;
	end

endmodule

### rtl/core/sacw_checker.sv
`include "set_assoc_lru_write_through_cache_assert.svh"

module sacw_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input sacw_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input sacw_pkg::rsp_t rsp
);

	// a stalled result beat holds
	`SACW_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	// one item in flight: no request taken right after one is accepted
	`SACW_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)
	// a new result only comes out of work in progress
	`SACW_ASSERT_IMP(a_rsp_from_work, $rose(rsp_valid), $past(!req_ready))

endmodule

bind set_assoc_lru_write_through_cache sacw_checker u_sacw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
